// ===== hdl/rlmd_pkg.sv =====
// Shared types, constants and register indexes of the run-length line mask decoder.
// No dependencies; every other file refers into this package by scoped names.
package rlmd_pkg;

    localparam int ADDR_BITS  = 20;  // width of the internal frame address counters
    localparam int DEST_W     = 20;  // width of dest_address on the result port
    localparam int LEN_W      = 9;   // run length, 1..256
    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_END_OF_LINE = 3'd0,
        REG_CODE_FILL        = 3'd1,
        REG_CODE_SKIP        = 3'd2,
        REG_CODE_BLOCK       = 3'd3,
        REG_CODE_SOLO        = 3'd4,
        REG_LINE_STRIDE      = 3'd5,
        REG_MASK_LEVEL_BITS  = 3'd6,
        REG_FILTER_ENABLE    = 3'd7
    } rlmd_reg_t;

    // byte class as seen in the code position
    typedef enum logic [2:0] {
        CLS_EOL,
        CLS_FILL,
        CLS_SKIP,
        CLS_BLOCK,
        CLS_SOLO,
        CLS_LIT
    } rlmd_cls_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_frame;
    } rlmd_in_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest_address;
        logic [LEN_W-1:0]  run_length;
        logic [PIX_W-1:0]  pixel_value;
        logic              write_flag;
    } rlmd_out_t;

    typedef struct packed {
        logic [7:0]  code_end_of_line;
        logic [7:0]  code_fill;
        logic [7:0]  code_skip;
        logic [7:0]  code_block;
        logic [7:0]  code_solo;
        logic [15:0] line_stride;
        logic [2:0]  mask_level_bits;
        logic        filter_enable;
    } rlmd_cfg_t;

    // one classified byte, as queued between front and back
    typedef struct packed {
        logic [7:0]       stream_byte;
        logic             start_of_frame;
        rlmd_cls_t        cls;
        logic [PIX_W-1:0] pixel;
    } rlmd_op_t;

    localparam rlmd_cfg_t CFG_RESET = '{
        code_end_of_line: 8'd0,
        code_fill:        8'd1,
        code_skip:        8'd2,
        code_block:       8'd3,
        code_solo:        8'd4,
        line_stride:      16'd320,
        mask_level_bits:  3'd0,
        filter_enable:    1'b0
    };

endpackage

// ===== hdl/rle_line_mask_decoder_top.sv =====
// Top level of the run-length line mask decoder: configuration registers plus
// front classifier, queue and back sequencer. Depends on rlmd_pkg, rlmd_front,
// rlmd_queue and rlmd_back.
//
//  Channel   Signals                              Moves
//  --------  -----------------------------------  ---------------------------------
//  byte      byte_valid/byte_ready/byte_item      one compressed stream byte + SOF
//  run       run_valid/run_ready/run_item         one run descriptor (addr,len,val,wr)
//  cfg       cfg_valid/cfg_ready/cfg_index/data   one register write request
//
// One byte request per cycle is sustained while run_ready stays high; a byte that
// yields a run is registered in the queue and then in the result register, from
// which its run request is offered. The rate is set by the back sequencer, which
// retires one queued byte per cycle whenever its result register is empty or
// being drained.
// Reset (rst_n low, asynchronous) empties the queue and result register and loads
// the register defaults: codes 0..4, stride 320, filter off.
// A stall on the run port holds the result register; the two-entry queue keeps
// taking bytes until it fills, then byte_ready drops. Config writes never stall.
module rle_line_mask_decoder_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 byte_valid,
    output logic                                 byte_ready,
    input  rlmd_pkg::rlmd_in_t                   byte_item,
    output logic                                 run_valid,
    input  logic                                 run_ready,
    output rlmd_pkg::rlmd_out_t                  run_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rlmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlmd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rlmd_pkg::rlmd_cfg_t cfg_reg, cfg_next;
    rlmd_pkg::rlmd_op_t  push_op, pop_op;
    logic push_valid, push_space;
    logic pop_valid, pop_ready;

    // register file; writes are always accepted
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (rlmd_pkg::rlmd_reg_t'(cfg_index))
                rlmd_pkg::REG_CODE_END_OF_LINE: cfg_next.code_end_of_line = cfg_data[7:0];
                rlmd_pkg::REG_CODE_FILL:        cfg_next.code_fill        = cfg_data[7:0];
                rlmd_pkg::REG_CODE_SKIP:        cfg_next.code_skip        = cfg_data[7:0];
                rlmd_pkg::REG_CODE_BLOCK:       cfg_next.code_block       = cfg_data[7:0];
                rlmd_pkg::REG_CODE_SOLO:        cfg_next.code_solo        = cfg_data[7:0];
                rlmd_pkg::REG_LINE_STRIDE:      cfg_next.line_stride      = cfg_data;
                rlmd_pkg::REG_MASK_LEVEL_BITS:  cfg_next.mask_level_bits  = cfg_data[2:0];
                rlmd_pkg::REG_FILTER_ENABLE:    cfg_next.filter_enable    = cfg_data[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= rlmd_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // front: classify the byte against the code registers, form the pixel value
    rlmd_front u_front (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_space (push_space),
        .push_op    (push_op)
    );

    // decouples the accept side from result-port stalls
    rlmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_space (push_space),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // back: decode state, address tracking and the result register
    rlmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run_item  (run_item)
    );

endmodule

// ===== hdl/rlmd_front.sv =====
// Front end: accepts stream bytes, matches them against the code registers and
// forms the pixel value. Depends on rlmd_pkg.
module rlmd_front (
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  rlmd_pkg::rlmd_in_t   byte_item,
    input  rlmd_pkg::rlmd_cfg_t  cfg,
    output logic                 push_valid,
    input  logic                 push_space,
    output rlmd_pkg::rlmd_op_t   push_op
);

    logic [7:0]  b;
    logic [3:0]  shift_s;
    logic [7:0]  hi_bits;
    logic [11:0] lvl_wide;
    logic [7:0]  low_mask;
    rlmd_pkg::rlmd_cls_t cls;

    assign b = byte_item.stream_byte;

    // priority order: end-of-line, fill, skip, block, solo
    always_comb
    begin
        if (b == cfg.code_end_of_line)
            cls = rlmd_pkg::CLS_EOL;
        else if (b == cfg.code_fill)
            cls = rlmd_pkg::CLS_FILL;
        else if (b == cfg.code_skip)
            cls = rlmd_pkg::CLS_SKIP;
        else if (b == cfg.code_block)
            cls = rlmd_pkg::CLS_BLOCK;
        else if (b == cfg.code_solo)
            cls = rlmd_pkg::CLS_SOLO;
        else
            cls = rlmd_pkg::CLS_LIT;
    end

    // level = ((v >> (8-m)) * 16) >> m, always below 16; index = v & (0xFF >> m)
    assign shift_s  = 4'd8 - {1'b0, cfg.mask_level_bits};
    assign hi_bits  = b >> shift_s;
    assign lvl_wide = {hi_bits, 4'b0000} >> cfg.mask_level_bits;
    assign low_mask = 8'hFF >> cfg.mask_level_bits;

    always_comb
    begin
        push_op.stream_byte    = b;
        push_op.start_of_frame = byte_item.start_of_frame;
        push_op.cls            = cls;
        if (cfg.filter_enable)
            push_op.pixel = {4'b0000, lvl_wide[3:0], b & low_mask};
        else
            push_op.pixel = {8'h00, b};
    end

    assign byte_ready = push_space;
    assign push_valid = byte_valid;

endmodule

// ===== hdl/rlmd_queue.sv =====
// Two-entry queue of classified bytes between front and back.
// Depends on rlmd_pkg.
module rlmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_space,
    input  rlmd_pkg::rlmd_op_t push_op,
    output logic               pop_valid,
    input  logic               pop_ready,
    output rlmd_pkg::rlmd_op_t pop_op
);

    rlmd_pkg::rlmd_op_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_space = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_space;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ===== hdl/rlmd_back.sv =====
// Back end: decode sequencer holding phase, cursor and line start; emits one run
// descriptor per output-producing byte into a result register. Depends on rlmd_pkg.
module rlmd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlmd_pkg::rlmd_cfg_t  cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  rlmd_pkg::rlmd_op_t   pop_op,
    output logic                 run_valid,
    input  logic                 run_ready,
    output rlmd_pkg::rlmd_out_t  run_item
);

    typedef enum logic [2:0] {
        PH_CODE,
        PH_COUNT,
        PH_FILLV,
        PH_BLOCK,
        PH_SOLO
    } phase_t;

    typedef enum logic [1:0] {
        PC_FILL,
        PC_SKIP,
        PC_BLOCK
    } pend_t;

    localparam int AW = rlmd_pkg::ADDR_BITS;
    localparam int LW = rlmd_pkg::LEN_W;

    phase_t  phase_reg, phase_next, phase_eff;
    pend_t   pend_reg, pend_next;
    logic [LW-1:0] rem_reg, rem_next, rem_eff, rem_dec;
    logic [AW-1:0] cursor_reg, cursor_next, cursor_eff;
    logic [AW-1:0] line_reg, line_next, line_eff, line_adv;
    logic          out_valid_reg, out_valid_next;
    rlmd_pkg::rlmd_out_t out_reg, out_next;

    logic          take, emit, wr;
    logic [LW-1:0] len;
    logic [rlmd_pkg::PIX_W-1:0] val;
    logic [LW-1:0] cnt;

    assign pop_ready = !out_valid_reg || run_ready;
    assign take      = pop_valid && pop_ready;
    assign run_valid = out_valid_reg;
    assign run_item  = out_reg;

    // start of frame drops any open sequence and rewinds to address zero
    assign phase_eff  = pop_op.start_of_frame ? PH_CODE : phase_reg;
    assign rem_eff    = pop_op.start_of_frame ? '0 : rem_reg;
    assign cursor_eff = pop_op.start_of_frame ? '0 : cursor_reg;
    assign line_eff   = pop_op.start_of_frame ? '0 : line_reg;
    assign line_adv   = line_eff + AW'(cfg.line_stride);
    assign cnt        = {1'b0, pop_op.stream_byte} + LW'(1);
    assign rem_dec    = (rem_eff != '0) ? rem_eff - LW'(1) : '0;

    always_comb
    begin
        phase_next = phase_eff;
        pend_next  = pend_reg;
        rem_next   = rem_eff;
        line_next  = line_eff;
        emit = 1'b0;
        len  = LW'(1);
        val  = pop_op.pixel;
        wr   = 1'b1;
        cursor_next = cursor_eff;
        case (phase_eff)
            PH_COUNT:
            begin
                if (pend_reg == PC_SKIP)
                begin
                    emit       = 1'b1;
                    len        = cnt;
                    val        = '0;
                    wr         = 1'b0;
                    phase_next = PH_CODE;
                end
                else
                begin
                    rem_next   = cnt;
                    phase_next = (pend_reg == PC_BLOCK) ? PH_BLOCK : PH_FILLV;
                end
            end
            PH_FILLV:
            begin
                emit       = 1'b1;
                len        = (rem_eff == '0) ? LW'(1) : rem_eff;
                rem_next   = '0;
                phase_next = PH_CODE;
            end
            PH_BLOCK:
            begin
                emit     = 1'b1;
                rem_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_CODE;
            end
            PH_SOLO:
            begin
                emit       = 1'b1;
                phase_next = PH_CODE;
            end
            default:
            begin
                phase_next = PH_CODE;
                case (pop_op.cls)
                    rlmd_pkg::CLS_EOL:
                    begin
                        line_next   = line_adv;
                        cursor_next = line_adv;
                    end
                    rlmd_pkg::CLS_FILL:
                    begin
                        pend_next  = PC_FILL;
                        phase_next = PH_COUNT;
                    end
                    rlmd_pkg::CLS_SKIP:
                    begin
                        pend_next  = PC_SKIP;
                        phase_next = PH_COUNT;
                    end
                    rlmd_pkg::CLS_BLOCK:
                    begin
                        pend_next  = PC_BLOCK;
                        phase_next = PH_COUNT;
                    end
                    rlmd_pkg::CLS_SOLO:
                        phase_next = PH_SOLO;
                    default:
                        emit = 1'b1;
                endcase
            end
        endcase
        if (emit)
            cursor_next = cursor_eff + AW'(len);

        out_next.dest_address = rlmd_pkg::DEST_W'(cursor_eff);
        out_next.run_length   = len;
        out_next.pixel_value  = val;
        out_next.write_flag   = wr;

        if (take && emit)
            out_valid_next = 1'b1;
        else if (run_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CODE;
            pend_reg      <= PC_FILL;
            rem_reg       <= '0;
            cursor_reg    <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                pend_reg   <= pend_next;
                rem_reg    <= rem_next;
                cursor_reg <= cursor_next;
                line_reg   <= line_next;
                if (emit)
                    out_reg <= out_next;
            end
        end
    end

endmodule
